@@ design/bstk_pkg.sv @@
`timescale 1ns / 1ps

package bstk_pkg;

	// Field widths fixed by the item formats
	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int VAL_W = 8;
	localparam int CNT_W = 9;

	// Instruction characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_MOD   = 8'h25;
	localparam logic [7:0] CH_NOT   = 8'h21;
	localparam logic [7:0] CH_GT    = 8'h60;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_DOWN  = 8'h76;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_UP    = 8'h5E;
	localparam logic [7:0] CH_RAND  = 8'h3F;
	localparam logic [7:0] CH_HIF   = 8'h5F;
	localparam logic [7:0] CH_VIF   = 8'h7C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DUP   = 8'h3A;
	localparam logic [7:0] CH_SWAP  = 8'h5C;
	localparam logic [7:0] CH_DROP  = 8'h24;
	localparam logic [7:0] CH_OUTI  = 8'h2E;
	localparam logic [7:0] CH_OUTC  = 8'h2C;
	localparam logic [7:0] CH_SKIP  = 8'h23;
	localparam logic [7:0] CH_GET   = 8'h67;
	localparam logic [7:0] CH_PUT   = 8'h70;
	localparam logic [7:0] CH_INI   = 8'h26;
	localparam logic [7:0] CH_INC   = 8'h7E;
	localparam logic [7:0] CH_END   = 8'h40;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_CHAR  = 3'd1,
		EV_INT   = 3'd2,
		EV_END   = 3'd3,
		EV_BAD   = 3'd4,
		EV_CRASH = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		CFG_UNSUP = 2'd0,
		CFG_DIVZ  = 2'd1,
		CFG_MODZ  = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] UNS_SKIP = 2'd1;
	localparam logic [1:0] UNS_REV  = 2'd2;
	localparam logic [1:0] MODZ_USER = 2'd0;
	localparam logic [1:0] MODZ_ZERO = 2'd1;

	typedef enum logic [4:0] {
		OP_NOP, OP_PUSHC, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NOT, OP_GT,
		OP_DIR, OP_RAND, OP_HIF, OP_VIF, OP_STR, OP_DUP, OP_SWAP, OP_DROP,
		OP_OUTI, OP_OUTC, OP_BRIDGE, OP_GET, OP_PUT, OP_IN, OP_END, OP_BAD
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_DECODE, S_POP, S_POPW, S_EXEC, S_DIV, S_GWAIT,
		S_PUSH, S_ADV, S_DONE
	} state_t;

	function automatic op_t decode(input logic [7:0] ch, input logic str);
		op_t op;
		op = OP_BAD;
		if (str && ch != CH_QUOTE) begin
			op = OP_PUSHC;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			op = OP_PUSHC;
		end else begin
			unique case (ch)
				CH_SPACE: op = OP_NOP;
				CH_ADD:   op = OP_ADD;
				CH_SUB:   op = OP_SUB;
				CH_MUL:   op = OP_MUL;
				CH_DIV:   op = OP_DIV;
				CH_MOD:   op = OP_MOD;
				CH_NOT:   op = OP_NOT;
				CH_GT:    op = OP_GT;
				CH_RIGHT, CH_DOWN, CH_LEFT, CH_UP: op = OP_DIR;
				CH_RAND:  op = OP_RAND;
				CH_HIF:   op = OP_HIF;
				CH_VIF:   op = OP_VIF;
				CH_QUOTE: op = OP_STR;
				CH_DUP:   op = OP_DUP;
				CH_SWAP:  op = OP_SWAP;
				CH_DROP:  op = OP_DROP;
				CH_OUTI:  op = OP_OUTI;
				CH_OUTC:  op = OP_OUTC;
				CH_SKIP:  op = OP_BRIDGE;
				CH_GET:   op = OP_GET;
				CH_PUT:   op = OP_PUT;
				CH_INI, CH_INC: op = OP_IN;
				CH_END:   op = OP_END;
				default:  op = OP_BAD;
			endcase
		end
		return op;
	endfunction

	function automatic logic [1:0] pop_count(input op_t op);
		logic [1:0] n;
		unique case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_SWAP, OP_GET: n = 2'd2;
			OP_NOT, OP_HIF, OP_VIF, OP_DUP, OP_DROP, OP_OUTI, OP_OUTC:     n = 2'd1;
			OP_PUT:  n = 2'd3;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

@@ design/befunge_stack_machine_core.sv @@
`timescale 1ns / 1ps
// Load item: written to the playfield on acceptance when in range; its result item is registered in S_DONE.
// Step item: FETCH, DECODE, POP/POPW per stack pop, EXEC, DIV for '/' or '%' (bit-serial
// divider), GWAIT for 'g', PUSH for up to 2 pushes, ADV per counter move, then DONE.
// One item at a time; playfield and stack sit in single-read-port RAMs.
// Reset (arst_n low) clears counter, heading, string mode, stack count,
// halt flag and configuration; playfield and stack contents are undefined.
module befunge_stack_machine_core #(
	parameter int FIELD_WIDTH  = 80,
	parameter int FIELD_HEIGHT = 25,
	parameter int STACK_DEPTH  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // cell_x[6:0] cell_y[11:7] cell_value[19:12]
	                              // user_value[27:20] random_dir[29:28] zero[31:30]
	input  logic        s_tuser,  // kind
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // out_value[7:0] pc_col[14:8] pc_row[19:15]
	                              // heading[21:20] in_string_mode[22]
	                              // stack_count[31:23] stack_overflow[32] zero[39:33]
	output logic [2:0]  m_tuser,  // event_res
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	localparam int PF_DEPTH = FIELD_WIDTH * FIELD_HEIGHT;
	localparam int PF_AW    = (PF_DEPTH > 1) ? $clog2(PF_DEPTH) : 1;
	localparam int ST_AW    = $clog2(STACK_DEPTH);
	localparam int SP_W     = $clog2(STACK_DEPTH + 1);

	bstk_pkg::state_t state_q, state_d;

	// architectural state
	logic [bstk_pkg::COL_W-1:0] col_q;
	logic [bstk_pkg::ROW_W-1:0] row_q;
	bstk_pkg::dir_t             dir_q;
	logic                       str_q;
	logic                       halted_q;
	logic [SP_W-1:0]            sp_q;
	logic [1:0]                 unsup_mode_q;
	logic                       divz_mode_q;
	logic [1:0]                 modz_mode_q;

	// per-item working registers
	logic [7:0]             user_q;
	bstk_pkg::dir_t         rnd_q;
	logic [7:0]             ch_q;
	bstk_pkg::op_t          op_q;
	logic [1:0]             npop_q, pi_q, npush_q, adv_q;
	logic                   dup_empty_q;
	logic [7:0]             pa_q, pb_q, pc_q;
	logic [7:0]             push0_q, push1_q;
	bstk_pkg::event_t       ev_q;
	logic [7:0]             val_q;
	logic                   drop_q;
	// divider
	logic [7:0]             dvd_q, dvs_q, rem_q;
	logic [2:0]             dcnt_q;

	// output register
	logic                   out_valid_q;
	logic [39:0]            out_data_q;
	logic [2:0]             out_ev_q;

	// memories
	logic             pf_we;
	logic [PF_AW-1:0] pf_waddr, pf_raddr;
	logic [7:0]       pf_wdata, pf_rdata;
	logic             st_we;
	logic [ST_AW-1:0] st_waddr, st_raddr;
	logic [7:0]       st_wdata, st_rdata;

	bstk_ram #(.WIDTH(8), .DEPTH(PF_DEPTH)) u_field (
		.clk(clk), .we(pf_we), .waddr(pf_waddr), .wdata(pf_wdata),
		.raddr(pf_raddr), .rdata(pf_rdata)
	);

	bstk_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	// input item fields
	logic       in_acc;
	logic [6:0] in_x;
	logic [4:0] in_y;
	logic       load_ok, get_ok, div_by_zero;
	logic [PF_AW-1:0] pc_addr, load_addr, gp_addr;

	assign in_acc   = s_tvalid && s_tready;
	assign in_x     = s_tdata[6:0];
	assign in_y     = s_tdata[11:7];
	assign load_ok  = (int'(in_x) < FIELD_WIDTH) && (int'(in_y) < FIELD_HEIGHT);
	assign pc_addr  = PF_AW'(int'(row_q) * FIELD_WIDTH + int'(col_q));
	assign load_addr = PF_AW'(int'(in_y) * FIELD_WIDTH + int'(in_x));
	// 'g' and 'p': y is the first pop, x the second; both signed
	assign get_ok   = !pa_q[7] && !pb_q[7] && (int'(pb_q[6:0]) < FIELD_WIDTH)
	                  && (int'(pa_q[6:0]) < FIELD_HEIGHT);
	assign gp_addr  = PF_AW'(int'(pa_q[6:0]) * FIELD_WIDTH + int'(pb_q[6:0]));
	assign div_by_zero = (pa_q == 8'd0);

	// one step of the counter in the current heading, wrapping at the edges
	logic [bstk_pkg::COL_W-1:0] col_nx;
	logic [bstk_pkg::ROW_W-1:0] row_nx;
	always_comb begin
		col_nx = col_q;
		row_nx = row_q;
		unique case (dir_q)
			bstk_pkg::DIR_RIGHT: col_nx = (int'(col_q) + 1 >= FIELD_WIDTH) ? '0 : col_q + 1'b1;
			bstk_pkg::DIR_DOWN:  row_nx = (int'(row_q) + 1 >= FIELD_HEIGHT) ? '0 : row_q + 1'b1;
			bstk_pkg::DIR_LEFT:  col_nx = (col_q == '0) ?
			                              bstk_pkg::COL_W'(FIELD_WIDTH - 1) : col_q - 1'b1;
			bstk_pkg::DIR_UP:    row_nx = (row_q == '0) ?
			                              bstk_pkg::ROW_W'(FIELD_HEIGHT - 1) : row_q - 1'b1;
			default: ;
		endcase
	end

	// divider step: shift in one dividend bit, subtract when it fits
	logic [8:0] trial;
	logic       qbit;
	logic [7:0] rem_nx, quo_nx, quo_s, rem_s;
	always_comb begin
		trial  = {rem_q, dvd_q[7]};
		qbit   = trial >= {1'b0, dvs_q};
		rem_nx = qbit ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
		quo_nx = {dvd_q[6:0], qbit};
		quo_s  = (pa_q[7] ^ pb_q[7]) ? 8'(-quo_nx) : quo_nx;
		rem_s  = pb_q[7] ? 8'(-rem_nx) : rem_nx;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bstk_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = (s_tuser && !halted_q) ? bstk_pkg::S_FETCH : bstk_pkg::S_DONE;
				end
			end
			bstk_pkg::S_FETCH:  state_d = bstk_pkg::S_DECODE;
			bstk_pkg::S_DECODE: begin
				state_d = (bstk_pkg::pop_count(bstk_pkg::decode(ch_q, str_q)) != 2'd0) ?
				          bstk_pkg::S_POP : bstk_pkg::S_EXEC;
			end
			bstk_pkg::S_POP: begin
				if (sp_q != '0) begin
					state_d = bstk_pkg::S_POPW;
				end else if (pi_q + 2'd1 == npop_q) begin
					state_d = bstk_pkg::S_EXEC;
				end
			end
			bstk_pkg::S_POPW: begin
				state_d = (pi_q + 2'd1 == npop_q) ? bstk_pkg::S_EXEC : bstk_pkg::S_POP;
			end
			bstk_pkg::S_EXEC: begin
				priority if ((op_q == bstk_pkg::OP_DIV || op_q == bstk_pkg::OP_MOD)
				             && !div_by_zero) begin
					state_d = bstk_pkg::S_DIV;
				end else if (op_q == bstk_pkg::OP_GET && get_ok) begin
					state_d = bstk_pkg::S_GWAIT;
				end else begin
					state_d = bstk_pkg::S_PUSH;
				end
			end
			bstk_pkg::S_DIV:   if (dcnt_q == 3'd7) state_d = bstk_pkg::S_PUSH;
			bstk_pkg::S_GWAIT: state_d = bstk_pkg::S_PUSH;
			bstk_pkg::S_PUSH:  if (npush_q == 2'd0) state_d = bstk_pkg::S_ADV;
			bstk_pkg::S_ADV:   if (adv_q == 2'd0) state_d = bstk_pkg::S_DONE;
			bstk_pkg::S_DONE:  if (!out_valid_q || m_tready) state_d = bstk_pkg::S_IDLE;
			default: state_d = bstk_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bstk_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memory ports
	always_comb begin
		pf_we    = 1'b0;
		pf_waddr = load_addr;
		pf_wdata = s_tdata[19:12];
		pf_raddr = pc_addr;
		st_we    = 1'b0;
		st_waddr = ST_AW'(sp_q);
		st_wdata = push0_q;
		st_raddr = ST_AW'(sp_q - 1'b1);
		unique case (state_q)
			bstk_pkg::S_IDLE: pf_we = in_acc && !s_tuser && load_ok;
			bstk_pkg::S_EXEC: begin
				pf_raddr = gp_addr;
				pf_waddr = gp_addr;
				pf_wdata = pc_q;
				pf_we    = (op_q == bstk_pkg::OP_PUT) && get_ok;
			end
			bstk_pkg::S_PUSH: st_we = (npush_q != 2'd0) && (int'(sp_q) < STACK_DEPTH);
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			dir_q        <= bstk_pkg::DIR_RIGHT;
			str_q        <= 1'b0;
			halted_q     <= 1'b0;
			sp_q         <= '0;
			unsup_mode_q <= '0;
			divz_mode_q  <= 1'b0;
			modz_mode_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bstk_pkg::CFG_UNSUP: unsup_mode_q <= cfg_data;
					bstk_pkg::CFG_DIVZ:  divz_mode_q  <= cfg_data[0];
					bstk_pkg::CFG_MODZ:  modz_mode_q  <= cfg_data;
					default: ;
				endcase
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bstk_pkg::S_POP: begin
					if (sp_q != '0) sp_q <= sp_q - 1'b1;
				end
				bstk_pkg::S_EXEC: begin
					unique case (op_q)
						bstk_pkg::OP_DIR:  dir_q <= bstk_pkg::dir_t'(ch_q == bstk_pkg::CH_RIGHT ?
						                      bstk_pkg::DIR_RIGHT : ch_q == bstk_pkg::CH_DOWN ?
						                      bstk_pkg::DIR_DOWN : ch_q == bstk_pkg::CH_LEFT ?
						                      bstk_pkg::DIR_LEFT : bstk_pkg::DIR_UP);
						bstk_pkg::OP_RAND: dir_q <= rnd_q;
						bstk_pkg::OP_HIF:  dir_q <= (pa_q == 8'd0) ? bstk_pkg::DIR_RIGHT :
						                                             bstk_pkg::DIR_LEFT;
						bstk_pkg::OP_VIF:  dir_q <= (pa_q == 8'd0) ? bstk_pkg::DIR_DOWN :
						                                             bstk_pkg::DIR_UP;
						bstk_pkg::OP_STR:  str_q <= !str_q;
						bstk_pkg::OP_END:  halted_q <= 1'b1;
						bstk_pkg::OP_MOD: begin
							if (div_by_zero && modz_mode_q != bstk_pkg::MODZ_USER
							    && modz_mode_q != bstk_pkg::MODZ_ZERO) halted_q <= 1'b1;
						end
						bstk_pkg::OP_BAD: begin
							priority if (unsup_mode_q == bstk_pkg::UNS_REV) begin
								dir_q <= bstk_pkg::dir_t'(dir_q + 2'd2);
							end else if (unsup_mode_q != bstk_pkg::UNS_SKIP) begin
								halted_q <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				bstk_pkg::S_PUSH: begin
					if (st_we) sp_q <= sp_q + 1'b1;
				end
				bstk_pkg::S_ADV: begin
					if (adv_q != 2'd0) begin
						col_q <= col_nx;
						row_q <= row_nx;
					end
				end
				bstk_pkg::S_DONE: begin
					if (!out_valid_q || m_tready) out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			bstk_pkg::S_IDLE: begin
				user_q  <= s_tdata[27:20];
				rnd_q   <= bstk_pkg::dir_t'(s_tdata[29:28]);
				ev_q    <= bstk_pkg::EV_NONE;
				val_q   <= '0;
				drop_q  <= 1'b0;
				npush_q <= '0;
				adv_q   <= '0;
				pi_q    <= '0;
				pa_q    <= '0;
				pb_q    <= '0;
				pc_q    <= '0;
			end
			bstk_pkg::S_FETCH: ch_q <= pf_rdata;
			bstk_pkg::S_DECODE: begin
				op_q        <= bstk_pkg::decode(ch_q, str_q);
				npop_q      <= bstk_pkg::pop_count(bstk_pkg::decode(ch_q, str_q));
				dup_empty_q <= (sp_q == '0);
			end
			bstk_pkg::S_POP: begin
				// empty stack pops give zero, already held in the operand
				if (sp_q == '0) pi_q <= pi_q + 2'd1;
			end
			bstk_pkg::S_POPW: begin
				unique case (pi_q)
					2'd0:    pa_q <= st_rdata;
					2'd1:    pb_q <= st_rdata;
					default: pc_q <= st_rdata;
				endcase
				pi_q <= pi_q + 2'd1;
			end
			bstk_pkg::S_EXEC: begin
				adv_q   <= 2'd1;
				npush_q <= 2'd0;
				dvd_q   <= pb_q[7] ? 8'(-pb_q) : pb_q;
				dvs_q   <= pa_q[7] ? 8'(-pa_q) : pa_q;
				rem_q   <= '0;
				dcnt_q  <= '0;
				unique case (op_q)
					bstk_pkg::OP_PUSHC: begin
						push0_q <= str_q ? ch_q : 8'(ch_q - bstk_pkg::CH_ZERO);
						npush_q <= 2'd1;
					end
					bstk_pkg::OP_ADD: begin push0_q <= 8'(pa_q + pb_q); npush_q <= 2'd1; end
					bstk_pkg::OP_SUB: begin push0_q <= 8'(pb_q - pa_q); npush_q <= 2'd1; end
					bstk_pkg::OP_MUL: begin push0_q <= 8'(pa_q * pb_q); npush_q <= 2'd1; end
					bstk_pkg::OP_DIV: begin
						push0_q <= divz_mode_q ? 8'd0 : user_q;
						npush_q <= 2'd1;
					end
					bstk_pkg::OP_MOD: begin
						npush_q <= 2'd1;
						if (modz_mode_q == bstk_pkg::MODZ_USER) begin
							push0_q <= user_q;
						end else if (modz_mode_q == bstk_pkg::MODZ_ZERO) begin
							push0_q <= 8'd0;
						end else if (div_by_zero) begin
							// crash: nothing pushed, counter held
							npush_q <= 2'd0;
							adv_q   <= 2'd0;
							ev_q    <= bstk_pkg::EV_CRASH;
						end
					end
					bstk_pkg::OP_NOT: begin
						push0_q <= (pa_q == 8'd0) ? 8'd1 : 8'd0;
						npush_q <= 2'd1;
					end
					bstk_pkg::OP_GT: begin
						push0_q <= ($signed(pb_q) > $signed(pa_q)) ? 8'd1 : 8'd0;
						npush_q <= 2'd1;
					end
					bstk_pkg::OP_DUP: begin
						push0_q <= pa_q;
						push1_q <= pa_q;
						npush_q <= dup_empty_q ? 2'd1 : 2'd2;
					end
					bstk_pkg::OP_SWAP: begin
						push0_q <= pa_q;
						push1_q <= pb_q;
						npush_q <= 2'd2;
					end
					bstk_pkg::OP_OUTI: begin ev_q <= bstk_pkg::EV_INT;  val_q <= pa_q; end
					bstk_pkg::OP_OUTC: begin ev_q <= bstk_pkg::EV_CHAR; val_q <= pa_q; end
					bstk_pkg::OP_BRIDGE: adv_q <= 2'd2;
					bstk_pkg::OP_GET: begin push0_q <= 8'd0; npush_q <= 2'd1; end
					bstk_pkg::OP_IN:  begin push0_q <= user_q; npush_q <= 2'd1; end
					bstk_pkg::OP_END: begin adv_q <= 2'd0; ev_q <= bstk_pkg::EV_END; end
					bstk_pkg::OP_BAD: begin
						if (unsup_mode_q != bstk_pkg::UNS_REV
						    && unsup_mode_q != bstk_pkg::UNS_SKIP) begin
							adv_q <= 2'd0;
							ev_q  <= bstk_pkg::EV_BAD;
							val_q <= ch_q;
						end
					end
					default: ;
				endcase
			end
			bstk_pkg::S_DIV: begin
				rem_q  <= rem_nx;
				dvd_q  <= quo_nx;
				dcnt_q <= dcnt_q + 3'd1;
				push0_q <= (op_q == bstk_pkg::OP_DIV) ? quo_s : rem_s;
			end
			bstk_pkg::S_GWAIT: push0_q <= pf_rdata;
			bstk_pkg::S_PUSH: begin
				if (npush_q != 2'd0) begin
					if (!st_we) drop_q <= 1'b1;
					push0_q <= push1_q;
					npush_q <= npush_q - 2'd1;
				end
			end
			bstk_pkg::S_ADV: begin
				if (adv_q != 2'd0) adv_q <= adv_q - 2'd1;
			end
			bstk_pkg::S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_ev_q   <= ev_q;
					out_data_q <= {7'd0, drop_q, bstk_pkg::CNT_W'(sp_q), str_q, dir_q,
					               row_q, col_q, val_q};
				end
			end
			default: ;
		endcase
	end

	assign s_tready  = (state_q == bstk_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_ev_q;

`ifndef SYNTHESIS
	// stack count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n) int'(sp_q) <= STACK_DEPTH)
		else $error("stack count above depth");
	// only reset clears the halt flag
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |=> halted_q)
		else $error("halt flag cleared");
	// divider never runs with a zero divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bstk_pkg::S_DIV |-> dvs_q != 8'd0)
		else $error("divide by zero in divider");
	// a terminating event leaves the core halted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == bstk_pkg::EV_END || m_tuser == bstk_pkg::EV_BAD
		|| m_tuser == bstk_pkg::EV_CRASH) |-> halted_q)
		else $error("terminating event without halt");
`endif

endmodule

@@ design/bstk_ram.sv @@
`timescale 1ns / 1ps

module bstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ bench/befunge_stack_machine_core_tb.sv @@
`timescale 1ns / 1ps

module befunge_stack_machine_core_tb;
	import bstk_pkg::*;

	localparam int FW = 80;
	localparam int FH = 25;
	localparam int SD = 256;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic       kind;
		logic [6:0] x;
		logic [4:0] y;
		logic [7:0] cv;
		logic [7:0] uv;
		logic [1:0] rd;
	} cmd_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] val;
		logic [6:0] col;
		logic [4:0] row;
		logic [1:0] hd;
		logic       str;
		logic [8:0] cnt;
		logic       ovf;
	} status_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [1:0]  cfg_data;

	befunge_stack_machine_core dut (.*);

	// Shadow interpreter state
	logic [7:0] field_mem [FW*FH];
	logic [7:0] vstack [SD];
	int         depth;
	int         pc_x, pc_y;
	dir_t       hd;
	bit         strm, stopped, dropped;
	logic [1:0] m_uns, m_div, m_mod;

	cmd_t    pending [$];
	status_t awaited [$];
	int      errors;
	int      cycles;
	int      src_idle, snk_idle;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int s8(input logic [7:0] b);
		return int'($signed(b));
	endfunction

	function automatic void push_v(input int v);
		if (depth >= SD) begin
			dropped = 1;
		end else begin
			vstack[depth] = v[7:0];
			depth++;
		end
	endfunction

	function automatic int pop_v();
		if (depth == 0) return 0;
		depth--;
		return s8(vstack[depth]);
	endfunction

	function automatic void move_pc();
		case (hd)
			DIR_RIGHT: pc_x = (pc_x + 1 >= FW) ? 0 : pc_x + 1;
			DIR_DOWN:  pc_y = (pc_y + 1 >= FH) ? 0 : pc_y + 1;
			DIR_LEFT:  pc_x = (pc_x == 0) ? FW - 1 : pc_x - 1;
			default:   pc_y = (pc_y == 0) ? FH - 1 : pc_y - 1;
		endcase
	endfunction

	function automatic bit on_field(input int x, input int y);
		return x >= 0 && x < FW && y >= 0 && y < FH;
	endfunction

	function automatic bit known(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 1;
		case (c)
			CH_SPACE, CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_NOT, CH_GT,
			CH_RIGHT, CH_DOWN, CH_LEFT, CH_UP, CH_RAND, CH_HIF, CH_VIF,
			CH_QUOTE, CH_DUP, CH_SWAP, CH_DROP, CH_OUTI, CH_OUTC, CH_SKIP,
			CH_GET, CH_PUT, CH_INI, CH_INC, CH_END: return 1;
			default: return 0;
		endcase
	endfunction

	// Run the instruction under the counter; hand back the event and value
	function automatic event_t run_cell(input int usr, input logic [1:0] rnd,
			output int val);
		logic [7:0] c;
		int a, b, x, y;
		c = field_mem[pc_y*FW + pc_x];
		val = 0;
		if (strm && c != CH_QUOTE) begin
			push_v(s8(c));
			move_pc();
			return EV_NONE;
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			push_v(int'(c) - int'(CH_ZERO));
			move_pc();
			return EV_NONE;
		end
		case (c)
			CH_SPACE: ;
			CH_ADD: begin a = pop_v(); b = pop_v(); push_v(a + b); end
			CH_SUB: begin a = pop_v(); b = pop_v(); push_v(b - a); end
			CH_MUL: begin a = pop_v(); b = pop_v(); push_v(a * b); end
			CH_DIV: begin
				a = pop_v(); b = pop_v();
				if (a != 0) push_v(b / a);
				else push_v(m_div[0] ? 0 : usr);
			end
			CH_MOD: begin
				a = pop_v(); b = pop_v();
				if (a != 0) push_v(b % a);
				else if (m_mod == MODZ_USER) push_v(usr);
				else if (m_mod == MODZ_ZERO) push_v(0);
				else begin
					stopped = 1;
					return EV_CRASH;
				end
			end
			CH_NOT: begin a = pop_v(); push_v(a == 0); end
			CH_GT: begin a = pop_v(); b = pop_v(); push_v(b > a); end
			CH_RIGHT: hd = DIR_RIGHT;
			CH_DOWN:  hd = DIR_DOWN;
			CH_LEFT:  hd = DIR_LEFT;
			CH_UP:    hd = DIR_UP;
			CH_RAND:  hd = dir_t'(rnd);
			CH_HIF: begin a = pop_v(); hd = (a == 0) ? DIR_RIGHT : DIR_LEFT; end
			CH_VIF: begin a = pop_v(); hd = (a == 0) ? DIR_DOWN : DIR_UP; end
			CH_QUOTE: strm = !strm;
			CH_DUP: begin
				if (depth == 0) push_v(0);
				else begin a = pop_v(); push_v(a); push_v(a); end
			end
			CH_SWAP: begin a = pop_v(); b = pop_v(); push_v(a); push_v(b); end
			CH_DROP: a = pop_v();
			CH_OUTI: begin val = pop_v(); move_pc(); return EV_INT; end
			CH_OUTC: begin val = pop_v(); move_pc(); return EV_CHAR; end
			CH_SKIP: move_pc();
			CH_GET: begin
				y = pop_v(); x = pop_v();
				push_v(on_field(x, y) ? s8(field_mem[y*FW + x]) : 0);
			end
			CH_PUT: begin
				y = pop_v(); x = pop_v(); a = pop_v();
				if (on_field(x, y)) field_mem[y*FW + x] = a[7:0];
			end
			CH_INI, CH_INC: push_v(usr);
			CH_END: begin stopped = 1; return EV_END; end
			default: begin
				if (m_uns == UNS_SKIP) ;
				else if (m_uns == UNS_REV) hd = dir_t'(2'(hd + 2'd2));
				else begin
					stopped = 1;
					val = s8(c);
					return EV_BAD;
				end
			end
		endcase
		move_pc();
		return EV_NONE;
	endfunction

	function automatic status_t predict(input cmd_t it);
		status_t r;
		int v;
		event_t ev;
		ev = EV_NONE;
		v = 0;
		dropped = 0;
		if (!it.kind) begin
			if (it.x < FW && it.y < FH) field_mem[it.y*FW + it.x] = it.cv;
		end else if (!stopped) begin
			ev = run_cell(s8(it.uv), it.rd, v);
		end
		r.ev  = ev;
		r.val = v[7:0];
		r.col = pc_x[6:0];
		r.row = pc_y[4:0];
		r.hd  = hd;
		r.str = strm;
		r.cnt = depth[8:0];
		r.ovf = dropped;
		return r;
	endfunction

	// Would the next step halt the core for good?
	function automatic bit halts_next();
		logic [7:0] c;
		c = field_mem[pc_y*FW + pc_x];
		if (stopped || (strm && c != CH_QUOTE)) return 0;
		if (c == CH_END) return 1;
		if (c == CH_MOD && m_mod > MODZ_ZERO && (depth == 0 || vstack[depth-1] == 0))
			return 1;
		return !known(c) && m_uns != UNS_SKIP && m_uns != UNS_REV;
	endfunction

	function automatic void send(input cmd_t it);
		awaited.push_back(predict(it));
		pending.push_back(it);
	endfunction

	function automatic void load_cell(input int x, input int y, input logic [7:0] v);
		cmd_t it;
		it = '0;
		it.x = x[6:0];
		it.y = y[4:0];
		it.cv = v;
		it.uv = 8'($urandom_range(0, 255));
		it.rd = 2'($urandom_range(0, 3));
		send(it);
	endfunction

	function automatic void step(input logic [7:0] u, input logic [1:0] r);
		cmd_t it;
		it.kind = 1;
		it.x = 7'($urandom_range(0, 127));
		it.y = 5'($urandom_range(0, 31));
		it.cv = 8'($urandom_range(0, 255));
		it.uv = u;
		it.rd = r;
		send(it);
	endfunction

	// Place one instruction under the counter and execute it
	function automatic void run_char(input logic [7:0] ch, input logic [7:0] u);
		load_cell(pc_x, pc_y, ch);
		step(u, 2'($urandom_range(0, 3)));
	endfunction

	function automatic logic [7:0] rand_op();
		logic [7:0] ops [26] = '{CH_SPACE, CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD,
			CH_NOT, CH_GT, CH_RIGHT, CH_DOWN, CH_LEFT, CH_UP, CH_RAND, CH_HIF,
			CH_VIF, CH_QUOTE, CH_DUP, CH_SWAP, CH_DROP, CH_OUTI, CH_OUTC,
			CH_SKIP, CH_GET, CH_PUT, CH_INI, CH_INC};
		logic [7:0] c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) c = CH_ZERO + 8'($urandom_range(0, 9));
		else if (pick < 90) c = ops[$urandom_range(0, 25)];
		else c = 8'($urandom_range(0, 255));
		return (c == CH_END) ? CH_SPACE : c;
	endfunction

	task automatic wait_drained();
		while (pending.size() != 0 || awaited.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [1:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
		case (idx)
			CFG_UNSUP: m_uns = v;
			CFG_DIVZ:  m_div = v;
			default:   m_mod = v;
		endcase
	endtask

	task automatic random_phase(input int n, input int si, input int ki,
			input logic [1:0] uns, input logic [1:0] dv, input logic [1:0] md,
			input bit hold_mid);
		wait_drained();
		write_reg(CFG_UNSUP, uns);
		write_reg(CFG_DIVZ, dv);
		write_reg(CFG_MODZ, md);
		src_idle = si;
		snk_idle = ki;
		for (int i = 0; i < n; i++) begin
			// Hold the sender once until the core has caught up
			if (hold_mid && i == n / 2) wait_drained();
			if ($urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 9) == 0)
					load_cell($urandom_range(0, 127), $urandom_range(0, 31), rand_op());
				else
					load_cell($urandom_range(0, FW-1), $urandom_range(0, FH-1), rand_op());
			end else begin
				// Overwrite a halting cell so the program keeps running
				if (halts_next()) load_cell(pc_x, pc_y, CH_SPACE);
				step(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
			end
		end
	endtask

	// Sender: advance to the next pending item when the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
			s_tuser  <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (pending.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
				cmd_t it;
				it = pending.pop_front();
				s_tvalid <= 1;
				s_tdata  <= {2'b00, it.rd, it.uv, it.cv, it.y, it.x};
				s_tuser  <= it.kind;
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	task automatic check_field(input string name, input int e, input int a);
		if (e != a) begin
			errors++;
			$display("%0t %s: expected %0d actual %0d", $realtime, name, e, a);
		end
	endtask

	// Receiver: stall at random, check each item against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle);
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t unexpected item: expected none actual %h/%h",
						$realtime, m_tuser, m_tdata);
				end else begin
					status_t e;
					e = awaited.pop_front();
					check_field("event_res", e.ev, m_tuser);
					check_field("out_value", e.val, m_tdata[7:0]);
					check_field("pc_col", e.col, m_tdata[14:8]);
					check_field("pc_row", e.row, m_tdata[19:15]);
					check_field("heading", e.hd, m_tdata[21:20]);
					check_field("in_string_mode", e.str, m_tdata[22]);
					check_field("stack_count", e.cnt, m_tdata[31:23]);
					check_field("stack_overflow", e.ovf, m_tdata[32]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("befunge_stack_machine_core: mismatch");
			$finish;
		end
	end

	initial begin
		logic [7:0] dchar [$];
		logic [7:0] duser [$];
		int halt_kind;
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = CFG_UNSUP;
		cfg_data = 0;
		errors = 0;
		cycles = 0;
		src_idle = 11;
		snk_idle = 51;
		depth = 0;
		pc_x = 0;
		pc_y = 0;
		hd = DIR_RIGHT;
		strm = 0;
		stopped = 0;
		m_uns = 0;
		m_div = 0;
		m_mod = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// Fill the whole playfield before any step, plus a few ignored loads
		for (int y = 0; y < FH; y++)
			for (int x = 0; x < FW; x++)
				load_cell(x, y, rand_op());
		for (int i = 0; i < 10; i++) begin
			load_cell($urandom_range(FW, 127), $urandom_range(0, 31), 8'hAA);
			load_cell($urandom_range(0, 127), $urandom_range(FH, 31), 8'h55);
		end
		wait_drained();
		write_reg(CFG_UNSUP, UNS_SKIP);

		// Directed: operand extremes, zero divisors, wrap cases, every operation but space and '@'
		dchar = '{CH_INI, CH_INC, CH_ADD, CH_ZERO, CH_DIV, CH_INI, CH_INI, CH_DIV,
			CH_INI, CH_INI, CH_MOD, CH_ZERO, CH_MOD, CH_NINE, CH_MUL, CH_SUB,
			CH_NOT, CH_GT, CH_DUP, CH_SWAP, CH_DROP, CH_OUTI, CH_OUTC, CH_QUOTE,
			CH_END, CH_QUOTE, CH_SKIP, CH_ZERO, CH_ZERO, CH_GET, CH_INI, CH_INI,
			CH_GET, CH_NINE, CH_ONE_PLACEHOLDER, CH_NINE, CH_PUT, CH_INI, CH_INI,
			CH_INI, CH_PUT, CH_RAND, CH_HIF, CH_VIF, CH_DOWN, CH_LEFT, CH_UP,
			CH_RIGHT, 8'h80, 8'h7F};
		duser = '{8'h7F, 8'h80, 8'h00, 8'h00, 8'h37, 8'h80, 8'hFF, 8'h00,
			8'h80, 8'hFF, 8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7F,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hB0, 8'h05, 8'h7F,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00};
		foreach (dchar[i]) run_char(dchar[i], duser[i]);
		// Fill the stack past its depth with duplicates
		run_char(CH_NINE, 8'h00);
		for (int i = 0; i < SD + 4; i++) run_char(CH_DUP, 8'h00);

		random_phase(320, 11, 51, UNS_SKIP, 2'd0, MODZ_USER, 1);
		random_phase(320, 51, 11, UNS_REV, 2'd1, MODZ_ZERO, 0);
		random_phase(320, 0, 0, 2'($urandom_range(1, 2)), 2'($urandom_range(0, 1)),
			2'($urandom_range(0, 1)), 0);

		// End on one halting case, then show that steps are dead afterwards
		wait_drained();
		halt_kind = $urandom_range(0, 2);
		write_reg(CFG_UNSUP, (halt_kind == 0) ? 2'd3 : 2'd0);
		write_reg(CFG_MODZ, (halt_kind == 2) ? 2'd3 : 2'd2);
		if (strm) run_char(CH_QUOTE, 8'h00);
		if (halt_kind == 0) run_char(8'h80, 8'h00);
		else if (halt_kind == 1) run_char(CH_END, 8'h00);
		else begin
			run_char(CH_ZERO, 8'h00);
			run_char(CH_MOD, 8'h00);
		end
		for (int i = 0; i < 6; i++) run_char(rand_op(), 8'($urandom_range(0, 255)));

		wait_drained();
		repeat (40) @(negedge clk);
		if (errors == 0) begin
			$display("befunge_stack_machine_core: match");
		end else begin
			$display("befunge_stack_machine_core: mismatch");
		end
		$finish;
	end

	localparam logic [7:0] CH_ONE_PLACEHOLDER = 8'h31;

endmodule

@@ befunge_stack_machine_core.f @@
design/bstk_pkg.sv
design/bstk_ram.sv
design/befunge_stack_machine_core.sv
bench/befunge_stack_machine_core_tb.sv
